FILE: rtl/core/bleb_pkg.sv
package bleb_pkg;

   localparam int MEM_BYTES = 65536;
   localparam int LANES     = 8;
   localparam int LANE_W    = $clog2(LANES);
   localparam int ROWS      = MEM_BYTES / LANES;
   localparam int ROW_W     = $clog2(ROWS);

   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [1:0]  access_size;
      logic [63:0] address;
      logic [63:0] write_data;
   } req_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic        fault;
   } rsp_type;

   // Combinational command broadcast to every byte lane.
   typedef struct packed {
      logic              clear;   // clearing pass: write zero at row
      logic              en;      // in-bounds access this cycle
      logic              write;
      logic [LANE_W-1:0] shift;   // offset bits below the row
      logic [1:0]        size;
      logic [ROW_W-1:0]  row;     // row of the first byte, or clear row
      logic [63:0]       wdata;
   } lane_cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_WAIT
   } state_type;

   // True when byte position idx lies inside an access of 2**size bytes.
   function automatic logic byte_used(input logic [LANE_W-1:0] idx,
                                      input logic [1:0] size);
      logic [LANE_W-1:0] hi;
      hi = idx >> size;
      return (hi == '0);
   endfunction

endpackage

FILE: rtl/core/bleb_ram.sv
module bleb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/bleb_lane.sv
module bleb_lane (
   input  logic                         clock,
   input  logic [bleb_pkg::LANE_W-1:0]  lane_id,
   input  bleb_pkg::lane_cmd_type       cmd,
   output logic [7:0]                   rdata
);

   logic [bleb_pkg::LANE_W-1:0] idx;
   logic                        wrap;
   logic [bleb_pkg::ROW_W-1:0]  row;
   logic                        we;
   logic [7:0]                  wbyte;

   // Byte idx of the access lands on this lane; lanes below the shift
   // hold bytes that spilled into the next row.
   assign idx  = lane_id - cmd.shift;
   assign wrap = (lane_id < cmd.shift);

   always_comb begin
      if (cmd.clear) begin
         row   = cmd.row;
         we    = 1'b1;
         wbyte = 8'h00;
      end else begin
         row   = cmd.row + bleb_pkg::ROW_W'(wrap);
         we    = cmd.en && cmd.write && bleb_pkg::byte_used(idx, cmd.size);
         wbyte = cmd.wdata[{idx, 3'b000} +: 8];
      end
   end

   bleb_ram #(
      .WIDTH (8),
      .DEPTH (bleb_pkg::ROWS)
   ) u_bank (
      .clock (clock),
      .we    (we),
      .addr  (row),
      .wdata (wbyte),
      .rdata (rdata)
   );

endmodule

FILE: rtl/core/bleb_merge.sv
module bleb_merge (
   input  logic [7:0]                  lane_data [bleb_pkg::LANES],
   input  logic [bleb_pkg::LANE_W-1:0] shift,
   input  logic [1:0]                  size,
   input  logic                        mode,
   input  logic                        fault,
   output logic [63:0]                 read_data
);

   logic [bleb_pkg::LANE_W-1:0] src [bleb_pkg::LANES];

   // Rotate lane bytes back into access order; zero unused bytes, and all bytes on a fault or a write.
   always_comb begin
      read_data = '0;
      for (int i = 0; i < bleb_pkg::LANES; i++) begin
         src[i] = shift + bleb_pkg::LANE_W'(i);
         if (!fault && mode == bleb_pkg::MODE_READ &&
             bleb_pkg::byte_used(bleb_pkg::LANE_W'(i), size)) begin
            read_data[8*i +: 8] = lane_data[src[i]];
         end
      end
   end

endmodule

FILE: rtl/core/bounded_le_byte_memory.sv
// Byte-addressed little-endian memory window with bounds check.
// Input: start/busy command port; an access transfer happens on a clock edge
//   with start high and busy low. req_data carries mode (0 read, 1 write),
//   access_size (log2 bytes), address and write_data. No alignment needed.
// Output: rsp_valid strobes for one cycle with rsp_data (read_data, fault).
//   The receiver cannot stall; every result is taken the cycle it shows.
// Config: csr_wr_en/csr_wr_data load base_address; write only while idle.
// Timing: the accept edge registers the request; the ACCESS state runs the
//   bounds check and the registered read or write of the byte-lane banks, and
//   WAIT loads the merged bytes into the response register. The result is then
//   on the ports and busy drops in that same cycle, so a new transfer may be
//   accepted at the edge that takes the result, and not before.
// Storage: 8 byte lanes, each a bank of MEM_BYTES/8 bytes, read or written
//   in parallel at a row and row+1 so any unaligned access fits in one pass;
//   a merge stage rotates lane bytes into access order.
// Reset: base_address goes to 0, then a clearing pass zeroes one row of all
//   lanes per cycle through all MEM_BYTES/8 rows (8192); busy is high meanwhile.
// Faults (below base or past the end, no wraparound) write nothing and
//   return read_data 0.
module bounded_le_byte_memory (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [63:0]       csr_wr_data,
   input  logic              start,
   output logic              busy,
   input  bleb_pkg::req_type req_data,
   output logic              rsp_valid,
   output bleb_pkg::rsp_type rsp_data
);

   localparam int LW = bleb_pkg::LANE_W;
   localparam int RW = bleb_pkg::ROW_W;

   bleb_pkg::state_type state_ff, state_in;

   logic [63:0]          base_ff;
   bleb_pkg::req_type    req_ff;
   logic [RW-1:0]        clear_row_ff, clear_row_in;
   logic                 fault_ff;
   logic [LW-1:0]        shift_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   bleb_pkg::rsp_type    rsp_ff, rsp_in;

   logic                 accept;
   logic                 clear_last;
   logic [64:0]          diff;
   logic [63:0]          count;
   logic [63:0]          limit;
   logic                 fault_now;
   bleb_pkg::lane_cmd_type cmd;
   logic [7:0]           lane_data [bleb_pkg::LANES];
   logic [63:0]          merged;

   assign accept     = start && !busy;
   assign clear_last = (clear_row_ff == RW'(bleb_pkg::ROWS - 1));

   // Bounds check: borrow of address - base means below the window.
   assign diff      = {1'b0, req_ff.address} - {1'b0, base_ff};
   assign count     = 64'(1) << req_ff.access_size;
   assign limit     = 64'(bleb_pkg::MEM_BYTES) - count;
   assign fault_now = diff[64] || (diff[63:0] > limit);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bleb_pkg::ST_CLEAR: begin
            if (clear_last) state_in = bleb_pkg::ST_IDLE;
         end
         bleb_pkg::ST_IDLE: begin
            if (start) state_in = bleb_pkg::ST_ACCESS;
         end
         bleb_pkg::ST_ACCESS: state_in = bleb_pkg::ST_WAIT;
         bleb_pkg::ST_WAIT:   state_in = bleb_pkg::ST_IDLE;
         default:             state_in = bleb_pkg::ST_IDLE;
      endcase
   end

   // Outputs and lane command
   always_comb begin
      busy         = 1'b1;
      clear_row_in = clear_row_ff;
      rsp_valid_in = 1'b0;
      cmd.clear    = 1'b0;
      cmd.en       = 1'b0;
      cmd.write    = req_ff.mode;
      cmd.shift    = diff[LW-1:0];
      cmd.size     = req_ff.access_size;
      cmd.row      = diff[RW+LW-1:LW];
      cmd.wdata    = req_ff.write_data;
      unique case (state_ff)
         bleb_pkg::ST_CLEAR: begin
            cmd.clear    = 1'b1;
            cmd.row      = clear_row_ff;
            clear_row_in = clear_row_ff + RW'(1);
         end
         bleb_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         bleb_pkg::ST_ACCESS: begin
            cmd.en = !fault_now;
         end
         bleb_pkg::ST_WAIT: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   genvar g;
   generate
      for (g = 0; g < bleb_pkg::LANES; g++) begin : g_lane
         bleb_lane u_lane (
            .clock   (clock),
            .lane_id (LW'(g)),
            .cmd     (cmd),
            .rdata   (lane_data[g])
         );
      end
   endgenerate

   bleb_merge u_merge (
      .lane_data (lane_data),
      .shift     (shift_ff),
      .size      (req_ff.access_size),
      .mode      (req_ff.mode),
      .fault     (fault_ff),
      .read_data (merged)
   );

   assign rsp_in.read_data = merged;
   assign rsp_in.fault     = fault_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bleb_pkg::ST_CLEAR;
         clear_row_ff <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_row_ff <= clear_row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) base_ff <= csr_wr_data;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      if (state_ff == bleb_pkg::ST_ACCESS) begin
         fault_ff <= fault_now;
         shift_ff <= diff[LW-1:0];
      end
      if (rsp_valid_in) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
